// ===== rtl/i2da_pkg.sv =====
// Shared types, constants and a helper function for the integer to decimal ASCII unit.
package i2da_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_W            = 32;
    localparam int MAG_W           = 32;
    localparam int DIGITS          = 10;
    localparam int BCD_W           = 4 * DIGITS;
    localparam int LEN_W           = 4;
    localparam int STEPS_PER_STAGE = 8;
    localparam int DD_STAGES       = MAG_W / STEPS_PER_STAGE;
    localparam int SHIFT_W         = 6;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [MAG_W-1:0] bin;
        logic             neg;
    } t_work;

    // One shift-and-add-3 step: correct each digit, then shift in the next binary bit.
    function automatic t_work dd_step(input t_work w);
        t_work            r;
        logic [BCD_W-1:0] adj;
        logic [3:0]       dig;
        adj = w.bcd;
        for (int d = 0; d < DIGITS; d++) begin
            dig = w.bcd[4*d +: 4];
            if (dig >= 4'd5) begin
                adj[4*d +: 4] = dig + 4'd3;
            end
        end
        r.bcd = {adj[BCD_W-2:0], w.bin[MAG_W-1]};
        r.bin = {w.bin[MAG_W-2:0], 1'b0};
        r.neg = w.neg;
        return r;
    endfunction

endpackage

// ===== rtl/i2da_front.sv =====
// Input stage: sign detection and magnitude extraction.
module i2da_front #(
    parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_mode,
    input  logic [i2da_pkg::IN_W-1:0]   i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output i2da_pkg::t_work             o_work
);
    localparam int EW = (VALUE_WIDTH < i2da_pkg::IN_W) ? VALUE_WIDTH : i2da_pkg::IN_W;
    localparam bit CAN_NEG = (VALUE_WIDTH <= i2da_pkg::IN_W);

    logic            r_valid;
    i2da_pkg::t_work r_work;
    i2da_pkg::t_work n_work;
    logic [EW-1:0]   v_ew;
    logic [EW-1:0]   m_ew;
    logic            neg;

    always_comb begin
        v_ew       = i_value[EW-1:0];
        neg        = CAN_NEG && i_mode && v_ew[EW-1];
        m_ew       = neg ? (~v_ew + 1'b1) : v_ew;
        n_work.bcd = '0;
        n_work.bin = i2da_pkg::MAG_W'(m_ew);
        n_work.neg = neg;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== rtl/i2da_dabble.sv =====
// One pipeline stage of the binary to BCD conversion, a fixed number of bits per stage.
module i2da_dabble (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  i2da_pkg::t_work i_work,
    output logic            o_valid,
    input  logic            i_ready,
    output i2da_pkg::t_work o_work
);
    logic            r_valid;
    i2da_pkg::t_work r_work;
    i2da_pkg::t_work n_work;

    always_comb begin
        n_work = i_work;
        for (int s = 0; s < i2da_pkg::STEPS_PER_STAGE; s++) begin
            n_work = i2da_pkg::dd_step(n_work);
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== rtl/i2da_format.sv =====
// Digit count, text length and left alignment of the BCD digits.
module i2da_format (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  i2da_pkg::t_work                i_work,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [i2da_pkg::BCD_W-1:0]     o_bcd,
    output logic                           o_neg,
    output logic [i2da_pkg::LEN_W-1:0]     o_len
);
    logic                         r_valid;
    logic [i2da_pkg::BCD_W-1:0]   r_bcd;
    logic                         r_neg;
    logic [i2da_pkg::LEN_W-1:0]   r_len;
    logic [i2da_pkg::LEN_W-1:0]   ndig;
    logic [i2da_pkg::SHIFT_W-1:0] sh;

    always_comb begin
        ndig = i2da_pkg::LEN_W'(1);
        for (int d = 1; d < i2da_pkg::DIGITS; d++) begin
            if (i_work.bcd[4*d +: 4] != 4'd0) begin
                ndig = i2da_pkg::LEN_W'(d + 1);
            end
        end
        sh = i2da_pkg::SHIFT_W'(i2da_pkg::DIGITS - ndig) << 2;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_bcd   = r_bcd;
    assign o_neg   = r_neg;
    assign o_len   = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bcd <= i_work.bcd << sh;
            r_neg <= i_work.neg;
            r_len <= ndig + i2da_pkg::LEN_W'(i_work.neg);
        end
    end

endmodule

// ===== rtl/i2da_serial.sv =====
// Output serializer: sign, then digits most significant first, in ASCII.
module i2da_serial (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [i2da_pkg::BCD_W-1:0] i_bcd,
    input  logic                       i_neg,
    input  logic [i2da_pkg::LEN_W-1:0] i_len,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_char_code,
    output logic [i2da_pkg::LEN_W-1:0] o_text_length,
    output logic                       o_is_last
);
    logic                       r_busy;
    logic [i2da_pkg::BCD_W-1:0] r_bcd;
    logic                       r_neg;
    logic [i2da_pkg::LEN_W-1:0] r_len;
    logic [i2da_pkg::LEN_W-1:0] r_left;
    logic                       take;
    logic                       last;

    assign last          = (r_left == i2da_pkg::LEN_W'(1));
    assign take          = r_busy && !i_stall;
    assign o_ready       = !r_busy || (take && last);
    assign o_valid       = r_busy;
    assign o_is_last     = last;
    assign o_text_length = r_len;
    assign o_char_code   = r_neg ? i2da_pkg::CHAR_MINUS
                                 : (i2da_pkg::CHAR_ZERO | {4'd0, r_bcd[i2da_pkg::BCD_W-1 -: 4]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_ready) begin
            r_busy <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            if (i_valid) begin
                r_bcd  <= i_bcd;
                r_neg  <= i_neg;
                r_len  <= i_len;
                r_left <= i_len;
            end
        end else if (take) begin
            r_left <= r_left - 1'b1;
            if (r_neg) begin
                r_neg <= 1'b0;
            end else begin
                r_bcd <= r_bcd << 4;
            end
        end
    end

endmodule

// ===== rtl/integer_to_decimal_ascii_unit.sv =====
// Integer to decimal ASCII unit: pipelined binary to BCD conversion and character serializer.
// An accepted request passes the front, dabble and format registers, then is loaded into the serializer.
// Throughput: one character per cycle while i_stall is low; a request yields 1 to 11 characters,
// set by its text length.
// Up to six further requests are held in the conversion pipeline meanwhile.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module integer_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic [i2da_pkg::IN_W-1:0]   i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_char_code,
    output logic [i2da_pkg::LEN_W-1:0]  o_text_length,
    output logic                        o_is_last
);
    localparam int NS = i2da_pkg::DD_STAGES;

    logic                       st_valid [NS+1];
    logic                       st_ready [NS+1];
    i2da_pkg::t_work            st_work  [NS+1];
    logic                       front_ready;
    logic                       fmt_ready;
    logic                       fmt_valid;
    logic [i2da_pkg::BCD_W-1:0] fmt_bcd;
    logic                       fmt_neg;
    logic [i2da_pkg::LEN_W-1:0] fmt_len;
    logic                       ser_ready;

    assign o_stall = !front_ready;

    i2da_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (front_ready),
        .i_mode  (i_mode),
        .i_value (i_value),
        .o_valid (st_valid[0]),
        .i_ready (st_ready[0]),
        .o_work  (st_work[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_dd
        i2da_dabble u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_work  (st_work[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_work  (st_work[g+1])
        );
    end

    assign st_ready[NS] = fmt_ready;

    i2da_format u_format (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[NS]),
        .o_ready (fmt_ready),
        .i_work  (st_work[NS]),
        .o_valid (fmt_valid),
        .i_ready (ser_ready),
        .o_bcd   (fmt_bcd),
        .o_neg   (fmt_neg),
        .o_len   (fmt_len)
    );

    i2da_serial u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (fmt_valid),
        .o_ready       (ser_ready),
        .i_bcd         (fmt_bcd),
        .i_neg         (fmt_neg),
        .i_len         (fmt_len),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_char_code   (o_char_code),
        .o_text_length (o_text_length),
        .o_is_last     (o_is_last)
    );

endmodule
